// ===== design/jdsu_pkg.sv =====
// ----------------------------------------------------------------------------
// jdsu_pkg
// Shared types, constants and the token table for the data string unwrapper.
// ----------------------------------------------------------------------------
package jdsu_pkg;

    localparam int unsigned QUEUE_DEPTH = 4;

    localparam logic [7:0] CH_QUOTE     = 8'h22;
    localparam logic [7:0] CH_COLON     = 8'h3A;
    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_SPACE     = 8'h20;

    // index of the closing quote of the token
    localparam logic [2:0] TOKEN_LAST = 3'd5;

    typedef enum logic [3:0] {
        PH_M0    = 4'd0,
        PH_M1    = 4'd1,
        PH_M2    = 4'd2,
        PH_M3    = 4'd3,
        PH_M4    = 4'd4,
        PH_M5    = 4'd5,
        PH_COLON = 4'd6,
        PH_QUOTE = 4'd7,
        PH_STR   = 4'd8,
        PH_ESC   = 4'd9
    } phase_t;

    typedef struct packed {
        logic [7:0] data;
        logic       has;
        logic       last;
    } res_t;

    typedef struct packed {
        logic wr;
        res_t res;
    } qwr_t;

    // the six bytes of "data" with its quotes
    function automatic logic [7:0] token_byte(input logic [2:0] idx);
        logic [7:0] r;
        case (idx)
            3'd0:    r = CH_QUOTE;
            3'd1:    r = 8'h64;
            3'd2:    r = 8'h61;
            3'd3:    r = 8'h74;
            3'd4:    r = 8'h61;
            3'd5:    r = CH_QUOTE;
            default: r = 8'h00;
        endcase
        return r;
    endfunction

    function automatic phase_t search_step(input logic [3:0] matched,
                                           input logic [7:0] b);
        logic [3:0] m;
        phase_t     r;
        m = (matched > {1'b0, TOKEN_LAST}) ? 4'd0 : matched;
        if (b == token_byte(m[2:0]))
        begin
            r = (m == {1'b0, TOKEN_LAST}) ? PH_COLON : phase_t'(m + 4'd1);
        end
        else if (b == CH_QUOTE)
        begin
            r = PH_M1;
        end
        else
        begin
            r = PH_M0;
        end
        return r;
    endfunction

endpackage

// ===== design/jdsu_front.sv =====
// ----------------------------------------------------------------------------
// jdsu_front
// Parse state machine: classifies each accepted byte and writes its result.
// ----------------------------------------------------------------------------
module jdsu_front
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  logic [7:0]        in_byte,
    input  logic              msg_end,
    input  logic              q_full,
    output logic              full,
    output jdsu_pkg::qwr_t    qwr
);

    jdsu_pkg::phase_t phase_reg;
    jdsu_pkg::phase_t phase_next;
    jdsu_pkg::phase_t step_phase;
    logic             pass;
    logic             accept;

    assign full   = q_full;
    assign accept = push & ~q_full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= jdsu_pkg::PH_M0;
        end
        else
        begin
            phase_reg <= phase_next;
        end
    end

    always_comb
    begin
        pass       = 1'b1;
        step_phase = phase_reg;
        case (phase_reg)
            jdsu_pkg::PH_COLON:
            begin
                if (in_byte <= jdsu_pkg::CH_SPACE)
                    step_phase = jdsu_pkg::PH_COLON;
                else if (in_byte == jdsu_pkg::CH_COLON)
                    step_phase = jdsu_pkg::PH_QUOTE;
                else
                    step_phase = jdsu_pkg::PH_M0;
            end
            jdsu_pkg::PH_QUOTE:
            begin
                if (in_byte <= jdsu_pkg::CH_SPACE)
                begin
                    step_phase = jdsu_pkg::PH_QUOTE;
                end
                else if (in_byte == jdsu_pkg::CH_QUOTE)
                begin
                    // opening quote is dropped
                    step_phase = jdsu_pkg::PH_STR;
                    pass       = 1'b0;
                end
                else
                begin
                    step_phase = jdsu_pkg::PH_M0;
                end
            end
            jdsu_pkg::PH_STR:
            begin
                if (in_byte == jdsu_pkg::CH_BACKSLASH)
                begin
                    step_phase = jdsu_pkg::PH_ESC;
                    pass       = 1'b0;
                end
                else if (in_byte == jdsu_pkg::CH_QUOTE)
                begin
                    step_phase = jdsu_pkg::PH_M0;
                    pass       = 1'b0;
                end
                else
                begin
                    step_phase = jdsu_pkg::PH_STR;
                end
            end
            jdsu_pkg::PH_ESC:
            begin
                step_phase = jdsu_pkg::PH_STR;
            end
            default:
            begin
                step_phase = jdsu_pkg::search_step(phase_reg, in_byte);
            end
        endcase

        phase_next = phase_reg;
        if (accept)
            phase_next = msg_end ? jdsu_pkg::PH_M0 : step_phase;

        qwr.wr       = accept;
        qwr.res.data = pass ? in_byte : 8'h00;
        qwr.res.has  = pass;
        qwr.res.last = msg_end;
    end

    // end of message always returns to token search
    a_end_resets: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && msg_end) |=> (phase_reg == jdsu_pkg::PH_M0))
        else $error("phase not cleared after message end");

    // bytes are only dropped at the opening quote or inside a string
    a_drop_place: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !qwr.res.has) |->
            (phase_reg == jdsu_pkg::PH_QUOTE || phase_reg == jdsu_pkg::PH_STR))
        else $error("byte dropped outside a string");

    // an escaped byte is always passed on
    a_esc_pass: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && phase_reg == jdsu_pkg::PH_ESC) |-> qwr.res.has)
        else $error("escaped byte dropped");

endmodule

// ===== design/jdsu_queue.sv =====
// ----------------------------------------------------------------------------
// jdsu_queue
// Short result queue between the parser and the output stage.
// ----------------------------------------------------------------------------
module jdsu_queue
#(
    parameter int unsigned DEPTH = jdsu_pkg::QUEUE_DEPTH
)
(
    input  logic           clk,
    input  logic           rst_n,
    input  jdsu_pkg::qwr_t qwr,
    input  logic           rd,
    output logic           q_full,
    output logic           q_empty,
    output jdsu_pkg::res_t rd_res
);

    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] PTR_MAX = AW'(DEPTH - 1);
    localparam logic [CW-1:0] CNT_MAX = CW'(DEPTH);

    jdsu_pkg::res_t  slot_reg [DEPTH];
    logic [AW-1:0]   wptr_reg;
    logic [AW-1:0]   wptr_next;
    logic [AW-1:0]   rptr_reg;
    logic [AW-1:0]   rptr_next;
    logic [CW-1:0]   count_reg;
    logic [CW-1:0]   count_next;
    logic            do_wr;
    logic            do_rd;

    assign q_full  = (count_reg == CNT_MAX);
    assign q_empty = (count_reg == '0);
    assign do_wr   = qwr.wr & ~q_full;
    assign do_rd   = rd & ~q_empty;
    assign rd_res  = slot_reg[rptr_reg];

    always_comb
    begin
        wptr_next  = wptr_reg;
        rptr_next  = rptr_reg;
        count_next = count_reg;
        if (do_wr)
            wptr_next = (wptr_reg == PTR_MAX) ? '0 : wptr_reg + AW'(1);
        if (do_rd)
            rptr_next = (rptr_reg == PTR_MAX) ? '0 : rptr_reg + AW'(1);
        if (do_wr && !do_rd)
            count_next = count_reg + CW'(1);
        else if (do_rd && !do_wr)
            count_next = count_reg - CW'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
            slot_reg[wptr_reg] <= qwr.res;
    end

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_MAX)
        else $error("queue count out of range");

    // a simultaneous write and read leaves the fill level unchanged
    a_count_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (do_wr && do_rd) |=> (count_reg == $past(count_reg)))
        else $error("queue count moved on write plus read");

endmodule

// ===== design/jdsu_back.sv =====
// ----------------------------------------------------------------------------
// jdsu_back
// Output stage: holds the oldest result and refills from the queue.
// ----------------------------------------------------------------------------
module jdsu_back
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           q_empty,
    input  jdsu_pkg::res_t rd_res,
    input  logic           pop,
    output logic           rd,
    output logic           empty,
    output logic [7:0]     out_byte,
    output logic           has_byte,
    output logic           out_last
);

    logic           valid_reg;
    logic           valid_next;
    jdsu_pkg::res_t hold_reg;
    logic           load;

    // refill when the stage is free or being drained this cycle
    assign load  = ~q_empty & (~valid_reg | pop);
    assign rd    = load;
    assign empty = ~valid_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
            valid_next = 1'b1;
        else if (pop)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
            hold_reg <= rd_res;
    end

    assign out_byte = hold_reg.data;
    assign has_byte = hold_reg.has;
    assign out_last = hold_reg.last;

endmodule

// ===== design/json_data_string_unwrapper.sv =====
// ----------------------------------------------------------------------------
// json_data_string_unwrapper
// Passes message bytes through and unwraps the string values of "data" keys.
// ----------------------------------------------------------------------------
// path: an accepted byte is written into the result queue, then loaded into the output stage
// throughput: one byte per cycle in and out while the queue is not full and pop is held
// the result queue plus the output stage let input run on while results wait
// reset: asynchronous, clears the parse phase to token search and empties the queue
module json_data_string_unwrapper
#(
    parameter int unsigned QUEUE_DEPTH = jdsu_pkg::QUEUE_DEPTH
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    output logic       full,
    input  logic [7:0] in_byte,
    input  logic       msg_end,
    output logic       empty,
    input  logic       pop,
    output logic [7:0] out_byte,
    output logic       has_byte,
    output logic       out_last
);

    jdsu_pkg::qwr_t qwr;
    jdsu_pkg::res_t rd_res;
    logic           q_full;
    logic           q_empty;
    logic           rd;

    jdsu_front u_front
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .in_byte (in_byte),
        .msg_end (msg_end),
        .q_full  (q_full),
        .full    (full),
        .qwr     (qwr)
    );

    jdsu_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .qwr     (qwr),
        .rd      (rd),
        .q_full  (q_full),
        .q_empty (q_empty),
        .rd_res  (rd_res)
    );

    jdsu_back u_back
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_empty  (q_empty),
        .rd_res   (rd_res),
        .pop      (pop),
        .rd       (rd),
        .empty    (empty),
        .out_byte (out_byte),
        .has_byte (has_byte),
        .out_last (out_last)
    );

endmodule

// ===== sim/tb_json_data_string_unwrapper.sv =====
// ----------------------------------------------------------------------------
// tb_json_data_string_unwrapper
// Drives whole messages into the unwrapper and checks every result against an
// in-bench parse of the "data" key strings, with random gaps and pop stalls.
// ----------------------------------------------------------------------------
module tb_json_data_string_unwrapper;

    localparam int unsigned WATCHDOG_LIMIT = 1000;
    localparam int unsigned TAIL_CYCLES    = 8;

    // token bytes, index 0 in the low byte
    localparam logic [47:0] KEY_SEQ = {jdsu_pkg::CH_QUOTE, 8'h61, 8'h74, 8'h61, 8'h64,
                                       jdsu_pkg::CH_QUOTE};

    logic       clk;
    logic       rst_n    = 1'b0;
    logic       push     = 1'b0;
    logic [7:0] in_byte  = 8'h00;
    logic       msg_end  = 1'b0;
    logic       pop      = 1'b0;
    logic       full;
    logic       empty;
    logic [7:0] out_byte;
    logic       has_byte;
    logic       out_last;

    jdsu_pkg::phase_t parse_st = jdsu_pkg::PH_M0;
    jdsu_pkg::res_t   pending_results[$];
    jdsu_pkg::res_t   rx_want;
    logic [7:0] msg_buf[$];
    logic [15:0] rx_cyc = '0;
    int         error_count = 0;
    int         idle_cycles = 0;
    int         burst_left  = 0;
    bit         push_on     = 1'b0;
    bit         steady      = 1'b0;

    json_data_string_unwrapper u_top
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .full     (full),
        .in_byte  (in_byte),
        .msg_end  (msg_end),
        .empty    (empty),
        .pop      (pop),
        .out_byte (out_byte),
        .has_byte (has_byte),
        .out_last (out_last)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // expected result for one byte, advances the tracked parse phase
    function automatic jdsu_pkg::res_t predict_unwrap(input logic [7:0] b, input logic last);
        jdsu_pkg::res_t   r;
        jdsu_pkg::phase_t nxt;
        logic             pass;
        int               idx;
        pass = 1'b1;
        nxt  = jdsu_pkg::PH_M0;
        case (parse_st)
            jdsu_pkg::PH_COLON:
            begin
                if (b <= jdsu_pkg::CH_SPACE)
                    nxt = jdsu_pkg::PH_COLON;
                else if (b == jdsu_pkg::CH_COLON)
                    nxt = jdsu_pkg::PH_QUOTE;
                else
                    nxt = jdsu_pkg::PH_M0;
            end
            jdsu_pkg::PH_QUOTE:
            begin
                if (b <= jdsu_pkg::CH_SPACE)
                    nxt = jdsu_pkg::PH_QUOTE;
                else if (b == jdsu_pkg::CH_QUOTE)
                begin
                    nxt  = jdsu_pkg::PH_STR;
                    pass = 1'b0;
                end
                else
                    nxt = jdsu_pkg::PH_M0;
            end
            jdsu_pkg::PH_STR:
            begin
                if (b == jdsu_pkg::CH_BACKSLASH)
                begin
                    nxt  = jdsu_pkg::PH_ESC;
                    pass = 1'b0;
                end
                else if (b == jdsu_pkg::CH_QUOTE)
                begin
                    nxt  = jdsu_pkg::PH_M0;
                    pass = 1'b0;
                end
                else
                    nxt = jdsu_pkg::PH_STR;
            end
            jdsu_pkg::PH_ESC:
                nxt = jdsu_pkg::PH_STR;
            default:
            begin
                idx = int'(parse_st);
                if (b == KEY_SEQ[idx*8 +: 8])
                    nxt = (idx == 5) ? jdsu_pkg::PH_COLON : jdsu_pkg::phase_t'(idx + 1);
                else if (b == jdsu_pkg::CH_QUOTE)
                    nxt = jdsu_pkg::PH_M1;
                else
                    nxt = jdsu_pkg::PH_M0;
            end
        endcase
        parse_st = last ? jdsu_pkg::PH_M0 : nxt;
        r.data = pass ? b : 8'h00;
        r.has  = pass;
        r.last = last;
        return r;
    endfunction

    // one input transfer, then maybe a gap between bursts
    task automatic send_item(input logic [7:0] b, input logic last);
        int gap;
        push    <= 1'b1;
        in_byte <= b;
        msg_end <= last;
        push_on = 1'b1;
        @(posedge clk);
        while (full)
            @(posedge clk);
        pending_results.push_back(predict_unwrap(b, last));
        if (!steady)
        begin
            if (burst_left == 0)
            begin
                gap = $urandom_range(1, 6);
                push <= 1'b0;
                push_on = 1'b0;
                repeat (gap) @(posedge clk);
                burst_left = $urandom_range(1, 20);
            end
            else
                burst_left--;
        end
    endtask

    task automatic send_str(input string s, input bit last_on_final);
        for (int i = 0; i < s.len(); i++)
            send_item(s[i], last_on_final && (i == s.len() - 1));
    endtask

    task automatic sender_idle();
        if (push_on)
            push <= 1'b0;
        push_on = 1'b0;
    endtask

    task automatic send_msg();
        for (int i = 0; i < msg_buf.size(); i++)
            send_item(msg_buf[i], i == msg_buf.size() - 1);
    endtask

    task automatic add_token(input int n);
        for (int i = 0; i < n; i++)
            msg_buf.push_back(KEY_SEQ[i*8 +: 8]);
    endtask

    task automatic add_ws();
        int n;
        n = $urandom_range(0, 2);
        repeat (n) msg_buf.push_back(8'($urandom_range(0, 32)));
    endtask

    // a byte above the whitespace range that is not the expected one
    function automatic logic [7:0] pick_wrong(input logic [7:0] excl);
        logic [7:0] c;
        c = 8'($urandom_range(33, 255));
        while (c == excl)
            c = 8'($urandom_range(33, 255));
        return c;
    endfunction

    // mostly well-formed data fields, with noise and broken fields mixed in
    task automatic build_message();
        int         nseg;
        int         kind;
        int         n;
        logic [7:0] c;
        msg_buf.delete();
        nseg = $urandom_range(1, 4);
        for (int s = 0; s < nseg; s++)
        begin
            kind = $urandom_range(0, 9);
            if (kind <= 5)
            begin
                add_token(6);
                add_ws();
                msg_buf.push_back(jdsu_pkg::CH_COLON);
                add_ws();
                msg_buf.push_back(jdsu_pkg::CH_QUOTE);
                n = $urandom_range(0, 8);
                for (int j = 0; j < n; j++)
                begin
                    if ($urandom_range(0, 4) == 0)
                    begin
                        msg_buf.push_back(jdsu_pkg::CH_BACKSLASH);
                        msg_buf.push_back(8'($urandom_range(0, 255)));
                    end
                    else
                    begin
                        c = 8'($urandom_range(0, 255));
                        while (c == jdsu_pkg::CH_QUOTE || c == jdsu_pkg::CH_BACKSLASH)
                            c = 8'($urandom_range(0, 255));
                        msg_buf.push_back(c);
                    end
                end
                msg_buf.push_back(jdsu_pkg::CH_QUOTE);
            end
            else if (kind == 6)
            begin
                n = $urandom_range(1, 6);
                repeat (n)
                    msg_buf.push_back(($urandom_range(0, 3) == 0)
                                      ? jdsu_pkg::CH_QUOTE
                                      : 8'($urandom_range(0, 255)));
            end
            else if (kind == 7)
            begin
                add_token($urandom_range(1, 5));
                msg_buf.push_back(8'($urandom_range(0, 255)));
            end
            else if (kind == 8)
            begin
                add_token(6);
                add_ws();
                msg_buf.push_back(pick_wrong(jdsu_pkg::CH_COLON));
            end
            else
            begin
                add_token(6);
                add_ws();
                msg_buf.push_back(jdsu_pkg::CH_COLON);
                add_ws();
                msg_buf.push_back(pick_wrong(jdsu_pkg::CH_QUOTE));
            end
        end
        // cut some messages short, often leaving a string or token open
        if ($urandom_range(0, 3) == 0)
        begin
            n = $urandom_range(1, msg_buf.size());
            while (msg_buf.size() > n)
                void'(msg_buf.pop_back());
        end
    endtask

    task automatic wait_drained();
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic test_extremes();
        send_item(8'h00, 1'b0);
        send_item(8'hFF, 1'b1);
    endtask

    // quote before the token, whitespace at both ends of its range, escapes,
    // closing quote, then a message ending part way into a new token
    task automatic test_field_unwrap();
        send_str("\"\"data\" :", 1'b0);
        send_item(8'h00, 1'b0);
        send_str("\"\\\"\"\"", 1'b1);
    endtask

    // wrong byte after the token (a quote, which must not open a new token)
    // and wrong byte after the colon
    task automatic test_broken_fields();
        send_str("\"data\"\"", 1'b0);
        send_str("\"data\":", 1'b0);
        send_item(8'hFF, 1'b1);
    endtask

    task automatic test_random_messages(input int n_items);
        int sent;
        sent = 0;
        while (sent < n_items)
        begin
            build_message();
            send_msg();
            sent += msg_buf.size();
        end
    endtask

    // sender holds off until everything sent so far has come back
    task automatic test_drain_pause();
        repeat (2)
        begin
            build_message();
            send_msg();
            sender_idle();
            wait_drained();
        end
    endtask

    task automatic test_no_gaps();
        int sent;
        sent   = 0;
        steady = 1'b1;
        while (sent < 80)
        begin
            build_message();
            send_msg();
            sent += msg_buf.size();
        end
        steady = 1'b0;
    endtask

    // result check and pop pattern
    always @(posedge clk)
    begin
        if (rst_n && pop && !empty)
        begin
            if (pending_results.size() == 0)
            begin
                error_count++;
                $error("result with nothing expected: out_byte %h has_byte %b out_last %b",
                       out_byte, has_byte, out_last);
            end
            else
            begin
                rx_want = pending_results.pop_front();
                if (out_byte !== rx_want.data)
                begin
                    error_count++;
                    $error("out_byte: expected %h, got %h", rx_want.data, out_byte);
                end
                if (has_byte !== rx_want.has)
                begin
                    error_count++;
                    $error("has_byte: expected %b, got %b", rx_want.has, has_byte);
                end
                if (out_last !== rx_want.last)
                begin
                    error_count++;
                    $error("out_last: expected %b, got %b", rx_want.last, out_last);
                end
            end
        end
        rx_cyc <= rx_cyc + 16'd1;
        case (rx_cyc[8:7])
            2'd0:    pop <= 1'b1;
            2'd1:    pop <= ($urandom_range(0, 1) == 1);
            2'd2:    pop <= (rx_cyc[2:0] == 3'd0);
            default: pop <= ($urandom_range(0, 4) != 0);
        endcase
    end

    // ends the run when no transfer happens for too long
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((push && !full) || (pop && !empty))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_extremes();
        test_field_unwrap();
        test_broken_fields();
        test_random_messages(600);
        test_drain_pause();
        test_no_gaps();
        sender_idle();
        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

// ===== json_data_string_unwrapper.f =====
design/jdsu_pkg.sv
design/jdsu_front.sv
design/jdsu_queue.sv
design/jdsu_back.sv
design/json_data_string_unwrapper.sv
sim/tb_json_data_string_unwrapper.sv
